// ----- src/gcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

  localparam int COORD_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CELL_W   = 8;
  localparam int NUM_W    = COORD_W + CELL_W;
  localparam int IDX_W    = 12;
  localparam int DEPTH    = 4096;
  localparam int QBITS    = 8;
  localparam int STEP_W   = $clog2(QBITS);

  localparam logic [CFG_IDX_W-1:0] CFG_X_LOWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_UPPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOWER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_UPPER = 3'd5;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_INDEX,
    ST_MEM,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  prep;
    logic  mul;
    logic  div_step;
    logic  store;
    logic  calc_index;
    logic  mem_access;
    axis_t axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/gcs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output gcs_pkg::ctrl_cmd_t      cmd,
  input  wire gcs_pkg::dp_status_t status
);
  import gcs_pkg::*;

  state_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_IDLE: begin
        axis_nxt = AXIS_X;
        if (start) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        case (axis_r)
          AXIS_X: begin
            axis_nxt  = AXIS_Y;
            state_nxt = ST_PREP;
          end
          AXIS_Y: begin
            axis_nxt  = AXIS_Z;
            state_nxt = ST_PREP;
          end
          default: begin
            axis_nxt  = AXIS_X;
            state_nxt = ST_INDEX;
          end
        endcase
      end
      ST_INDEX: state_nxt = ST_MEM;
      ST_MEM:   state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.axis       = axis_r;
    cmd.capture    = (state_r == ST_IDLE) && start;
    cmd.prep       = (state_r == ST_PREP);
    cmd.mul        = (state_r == ST_MUL);
    cmd.div_step   = (state_r == ST_DIV);
    cmd.store      = (state_r == ST_STORE);
    cmd.calc_index = (state_r == ST_INDEX);
    cmd.mem_access = (state_r == ST_MEM);
    busy           = (state_r != ST_IDLE);
    out_valid      = (state_r == ST_RESP);
  end

endmodule

`default_nettype wire

// ----- src/gcs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gcs_dp #(
  parameter int X_POINTS     = 16,
  parameter int Y_POINTS     = 16,
  parameter int Z_POINTS     = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gcs_pkg::COORD_W-1:0]   cfg_data,
  input  wire logic                          in_cmd,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_x_coord,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_y_coord,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_z_coord,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_write_value,
  input  wire gcs_pkg::ctrl_cmd_t            cmd,
  output gcs_pkg::dp_status_t                status,
  output logic [gcs_pkg::COORD_W-1:0]        out_sample_value,
  output logic [gcs_pkg::IDX_W-1:0]          out_cell_index
);
  import gcs_pkg::*;

  localparam int MEM_W = (SAMPLE_WIDTH < COORD_W) ? SAMPLE_WIDTH : COORD_W;
  localparam logic [CELL_W-1:0] X_TOP = CELL_W'(X_POINTS - 1);
  localparam logic [CELL_W-1:0] Y_TOP = CELL_W'(Y_POINTS - 1);
  localparam logic [CELL_W-1:0] Z_TOP = CELL_W'(Z_POINTS - 1);
  localparam logic [31:0] STRIDE_X = 32'(Y_POINTS * Z_POINTS);
  localparam logic [31:0] STRIDE_Y = 32'(Z_POINTS);

  // Configuration registers.
  logic [COORD_W-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r, z_lo_r, z_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lo_r <= '0;
      x_hi_r <= 32'h0001_0000;
      y_lo_r <= '0;
      y_hi_r <= 32'h0001_0000;
      z_lo_r <= '0;
      z_hi_r <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LOWER: x_lo_r <= cfg_data;
        CFG_X_UPPER: x_hi_r <= cfg_data;
        CFG_Y_LOWER: y_lo_r <= cfg_data;
        CFG_Y_UPPER: y_hi_r <= cfg_data;
        CFG_Z_LOWER: z_lo_r <= cfg_data;
        CFG_Z_UPPER: z_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item.
  logic               cmd_r;
  logic [COORD_W-1:0] x_r, y_r, z_r, wv_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      x_r   <= in_x_coord;
      y_r   <= in_y_coord;
      z_r   <= in_z_coord;
      wv_r  <= in_write_value;
    end
  end

  // Per-axis operand selection.
  logic [COORD_W-1:0] c_sel, lo_sel, hi_sel;
  logic [CELL_W-1:0]  top_sel;

  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        c_sel = x_r; lo_sel = x_lo_r; hi_sel = x_hi_r; top_sel = X_TOP;
      end
      AXIS_Y: begin
        c_sel = y_r; lo_sel = y_lo_r; hi_sel = y_hi_r; top_sel = Y_TOP;
      end
      default: begin
        c_sel = z_r; lo_sel = z_lo_r; hi_sel = z_hi_r; top_sel = Z_TOP;
      end
    endcase
  end

  logic [COORD_W:0] diff_w, span_w;
  assign diff_w = {c_sel[COORD_W-1], c_sel} - {lo_sel[COORD_W-1], lo_sel};
  assign span_w = {hi_sel[COORD_W-1], hi_sel} - {lo_sel[COORD_W-1], lo_sel};

  // Divider state: remainder and an 8-bit shift register that holds the low
  // numerator bits and collects quotient bits as they come out.
  logic [COORD_W-1:0] diff_r, span_r, rem_r;
  logic               empty_r, sat_r;
  logic [CELL_W-1:0]  top_r, low_r;
  logic [STEP_W-1:0]  step_r;
  logic [NUM_W-1:0]   num_w;
  logic [COORD_W:0]   trial_w, sub_w;

  assign num_w   = NUM_W'(diff_r) * NUM_W'(top_r);
  assign trial_w = {rem_r, low_r[CELL_W-1]};
  assign sub_w   = trial_w - {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      empty_r <= ($signed(hi_sel) <= $signed(lo_sel)) || ($signed(c_sel) <= $signed(lo_sel));
      diff_r  <= diff_w[COORD_W-1:0];
      span_r  <= span_w[COORD_W-1:0];
      top_r   <= top_sel;
    end
    if (cmd.mul) begin
      // At or beyond the upper bound the quotient clamps; below it the
      // quotient is under top, so eight quotient bits suffice.
      sat_r  <= (diff_r >= span_r);
      rem_r  <= num_w[NUM_W-1:CELL_W];
      low_r  <= num_w[CELL_W-1:0];
      step_r <= '0;
    end else if (cmd.div_step) begin
      if (!sub_w[COORD_W]) begin
        rem_r <= sub_w[COORD_W-1:0];
        low_r <= {low_r[CELL_W-2:0], 1'b1};
      end else begin
        rem_r <= trial_w[COORD_W-1:0];
        low_r <= {low_r[CELL_W-2:0], 1'b0};
      end
      step_r <= step_r + 1'b1;
    end
  end

  assign status.div_last = (step_r == STEP_W'(QBITS - 1));

  // Per-axis cell numbers.
  logic [CELL_W-1:0] ix_r, iy_r, iz_r, cell_w;

  assign cell_w = empty_r ? '0 : (sat_r ? top_r : low_r);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.axis)
        AXIS_X:  ix_r <= cell_w;
        AXIS_Y:  iy_r <= cell_w;
        default: iz_r <= cell_w;
      endcase
    end
  end

  logic [31:0]      lin_w;
  logic [IDX_W-1:0] idx_r;

  assign lin_w = 32'(ix_r) * STRIDE_X + 32'(iy_r) * STRIDE_Y + 32'(iz_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_index) idx_r <= lin_w[IDX_W-1:0];
  end

  // Sample store.
  logic [MEM_W-1:0] mem [DEPTH];
  logic [MEM_W-1:0] samp_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_access) begin
      if (cmd_r == CMD_WRITE) begin
        mem[idx_r] <= wv_r[MEM_W-1:0];
        samp_r     <= wv_r[MEM_W-1:0];
      end else begin
        samp_r     <= mem[idx_r];
      end
    end
  end

  assign out_sample_value = COORD_W'($signed(samp_r));
  assign out_cell_index   = idx_r;

endmodule

`default_nettype wire

// ----- src/grid_coordinate_sample_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake             Payload
// --------   -------------------   ---------------------------------------------
// input      start / busy          in_cmd, in_x_coord, in_y_coord, in_z_coord,
//                                  in_write_value
// result     out_valid (strobe)    out_sample_value, out_cell_index
// config     cfg_we                cfg_index, cfg_data
//
// Each of the three axes in turn passes through offset, multiply, eight quotient
// steps of the shared shift-subtract divider and clamp; then the linear index is
// formed, the sample memory is accessed and the result is shown. A new item is
// taken only in idle, which the block reaches again after the result strobe, so
// it cannot take the next item before the last result has been shown.
// Reset is synchronous and active low; it returns the axis bounds to their
// defaults. The sample memory has no reset and holds nothing until written.
// The result strobe lasts one cycle and the receiver cannot stall it.
module grid_coordinate_sample_store #(
  parameter int X_POINTS     = 16,
  parameter int Y_POINTS     = 16,
  parameter int Z_POINTS     = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gcs_pkg::COORD_W-1:0]   cfg_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_cmd,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_x_coord,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_y_coord,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_z_coord,
  input  wire logic [gcs_pkg::COORD_W-1:0]   in_write_value,
  output logic                               out_valid,
  output logic [gcs_pkg::COORD_W-1:0]        out_sample_value,
  output logic [gcs_pkg::IDX_W-1:0]          out_cell_index
);
  import gcs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller walks the three axes in turn and sequences the divider,
  // the index calculation and the memory access.
  gcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the bounds, the captured item, the divider and the
  // sample memory.
  gcs_dp #(
    .X_POINTS     (X_POINTS),
    .Y_POINTS     (Y_POINTS),
    .Z_POINTS     (Z_POINTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_z_coord       (in_z_coord),
    .in_write_value   (in_write_value),
    .cmd              (cmd),
    .status           (status),
    .out_sample_value (out_sample_value),
    .out_cell_index   (out_cell_index)
  );

  // An accepted item makes the block busy in the next cycle.
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The result strobe never stays high in back-to-back cycles.
  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A result only appears while an item is in flight.
  a_strobe_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy && $past(busy)))
    else $error("result strobe without an item in flight");

  // The divider only runs while the block is busy.
  a_div_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> busy)
    else $error("divider step while idle");

endmodule

`default_nettype wire
